@@ hdl/kte_pkg.sv @@
// ----------------------------------------------------------------------------
// kte_pkg
// Shared widths, codes and types for the key table with expiry.
// ----------------------------------------------------------------------------
package kte_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int HW_W        = $clog2(TABLE_DEPTH + 1);

  localparam int KEY_W    = 63;
  localparam int CODE_W   = 64;
  localparam int STAMP_W  = 32;
  localparam int EXPIRY_W = 31;
  localparam int SLOT_W   = 6;
  localparam int COUNT_W  = 7;

  localparam int APB_DATA_W = 32;
  localparam int PADDR_W    = 3;

  localparam logic [EXPIRY_W-1:0] EXPIRY_RESET = EXPIRY_W'(60 * 5);

  // register word index (paddr[2])
  localparam logic REG_EXPIRY = 1'b0;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SWEEP  = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [CODE_W-1:0]  code;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

endpackage

@@ hdl/kte_ifs.sv @@
// ----------------------------------------------------------------------------
// kte_req_if / kte_rsp_if
// Valid/ready channels for commands into and results out of the key table.
// ----------------------------------------------------------------------------
interface kte_req_if import kte_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                command;
  logic [KEY_W-1:0]    key;
  logic [CODE_W-1:0]   user_code;
  logic [STAMP_W-1:0]  now;

  modport source(output valid, command, key, user_code, now, input ready);
  modport sink(input valid, command, key, user_code, now, output ready);
endinterface

interface kte_rsp_if import kte_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               ok;
  logic [SLOT_W-1:0]  slot;
  logic [COUNT_W-1:0] removed_count;

  modport source(output valid, ok, slot, removed_count, input ready);
  modport sink(input valid, ok, slot, removed_count, output ready);
endinterface

@@ hdl/key_table_with_expiry_top.sv @@
// ----------------------------------------------------------------------------
// key_table_with_expiry_top
// Aging key table: first-free insert and expiry sweep below a high-water mark.
// ----------------------------------------------------------------------------
//  channel   | kind          | beat contents
//  ----------+---------------+-----------------------------------------
//  request   | valid/ready   | command, key, user_code, now
//  response  | valid/ready   | ok, slot, removed_count
//  apb       | APB, 32 bit   | expiry_seconds at byte address 0
//
//  Insert: entries are probed in order from slot 0, first free wins (1..64 probed).
//  Sweep: scans the entries below high_water; one memory port reads
//  an entry while the entry before it is checked and, if expired, cleared.
//  One command at a time; the next is taken while a result waits to go out.
//  Reset (rst, synchronous) frees every entry at once via the used bits.
//  A stalled response holds the engine in its final state, blocking requests.
// ----------------------------------------------------------------------------
module key_table_with_expiry_top import kte_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  kte_req_if.sink               request,
  kte_rsp_if.source             response
);

  logic [EXPIRY_W-1:0] expiry;

  kte_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .expiry  (expiry)
  );

  kte_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .expiry   (expiry),
    .request  (request),
    .response (response)
  );

endmodule

@@ hdl/kte_cfg.sv @@
// ----------------------------------------------------------------------------
// kte_cfg
// APB register bank holding the expiry interval.
// ----------------------------------------------------------------------------
module kte_cfg import kte_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [EXPIRY_W-1:0]   expiry
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      expiry <= EXPIRY_RESET;
    end else if (wr_en && paddr[2] == REG_EXPIRY) begin
      expiry <= pwdata[EXPIRY_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_EXPIRY) begin
      prdata = APB_DATA_W'(expiry);
    end
  end

endmodule

@@ hdl/kte_engine.sv @@
// ----------------------------------------------------------------------------
// kte_engine
// Entry memory, per-entry used bits and the sequencer for insert and sweep.
// ----------------------------------------------------------------------------
module kte_engine import kte_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [EXPIRY_W-1:0] expiry,
  kte_req_if.sink             request,
  kte_rsp_if.source           response
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INS   = 3'd1;
  localparam logic [2:0] ST_SWEEP = 3'd2;
  localparam logic [2:0] ST_DONE  = 3'd3;

  entry_t mem [TABLE_DEPTH];

  logic [2:0]             state;
  logic [TABLE_DEPTH-1:0] used;
  logic [HW_W-1:0]        high_water;

  // latched command
  logic [KEY_W-1:0]       cmd_key;
  logic [CODE_W-1:0]      cmd_code;
  logic [STAMP_W-1:0]     cmd_now;

  logic [IDX_W-1:0]       ins_idx;
  logic [HW_W-1:0]        rd_cnt;
  logic                   s1_valid;
  logic [IDX_W-1:0]       s1_idx;
  entry_t                 rd_data;
  logic [HW_W-1:0]        rm_cnt;

  logic                   res_ok;
  logic [SLOT_W-1:0]      res_slot;
  logic [COUNT_W-1:0]     res_count;

  logic                   out_valid;
  logic                   out_ok;
  logic [SLOT_W-1:0]      out_slot;
  logic [COUNT_W-1:0]     out_count;

  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  entry_t                 mem_wdata;
  logic [STAMP_W-1:0]     age;
  logic                   expire;
  logic                   accept;
  logic                   out_load;

  assign request.ready          = (state == ST_IDLE);
  assign accept                 = request.valid && request.ready;
  assign response.valid         = out_valid;
  assign response.ok            = out_ok;
  assign response.slot          = out_slot;
  assign response.removed_count = out_count;

  assign out_load = (state == ST_DONE) && (!out_valid || response.ready);
  assign age      = cmd_now - rd_data.stamp;
  assign expire   = s1_valid && used[s1_idx] && (age > STAMP_W'(expiry));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ins_idx;
    mem_wdata = '{key: cmd_key, code: cmd_code, stamp: cmd_now};
    if (state == ST_INS) begin
      mem_we = !used[ins_idx];
    end else if (state == ST_SWEEP) begin
      mem_we    = expire;
      mem_waddr = s1_idx;
      mem_wdata = '{key: '0, code: '0, stamp: rd_data.stamp};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_cnt[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      used       <= '0;
      high_water <= '0;
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (response.valid && response.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd_key  <= request.key;
            cmd_code <= request.user_code;
            cmd_now  <= request.now;
            ins_idx  <= '0;
            rd_cnt   <= '0;
            rm_cnt   <= '0;
            s1_valid <= 1'b0;
            state    <= (request.command == CMD_SWEEP) ? ST_SWEEP : ST_INS;
          end
        end
        ST_INS: begin
          if (!used[ins_idx]) begin
            used[ins_idx] <= (cmd_key != '0);
            if (HW_W'(ins_idx) >= high_water) begin
              high_water <= HW_W'(ins_idx) + HW_W'(1);
            end
            res_ok    <= 1'b1;
            res_slot  <= SLOT_W'(ins_idx);
            res_count <= '0;
            state     <= ST_DONE;
          end else if (ins_idx == IDX_W'(TABLE_DEPTH - 1)) begin
            res_ok    <= 1'b0;
            res_slot  <= '0;
            res_count <= '0;
            state     <= ST_DONE;
          end else begin
            ins_idx <= ins_idx + IDX_W'(1);
          end
        end
        ST_SWEEP: begin
          // read entry rd_cnt while the previous one is checked and, if expired, cleared
          if (rd_cnt != high_water) begin
            s1_valid <= 1'b1;
            s1_idx   <= rd_cnt[IDX_W-1:0];
            rd_cnt   <= rd_cnt + HW_W'(1);
          end else begin
            s1_valid <= 1'b0;
          end
          if (expire) begin
            used[s1_idx] <= 1'b0;
            rm_cnt       <= rm_cnt + HW_W'(1);
          end
          if (rd_cnt == high_water && !s1_valid) begin
            res_ok    <= 1'b1;
            res_slot  <= '0;
            res_count <= COUNT_W'(rm_cnt);
            state     <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            out_ok    <= res_ok;
            out_slot  <= res_slot;
            out_count <= res_count;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_hw_bound: assert property (@(posedge clk) disable iff (rst)
    high_water <= HW_W'(TABLE_DEPTH))
    else $error("high-water mark beyond table depth");

  a_used_below_hw: assert property (@(posedge clk) disable iff (rst)
    $countones(used) <= int'(high_water))
    else $error("more used entries than the high-water mark covers");

  a_pipe_in_sweep: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (state == ST_SWEEP))
    else $error("sweep read stage live outside a sweep");

  a_rm_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP) |-> (rm_cnt <= rd_cnt))
    else $error("removed count ahead of entries read");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && state == ST_IDLE))
    else $error("finished result not presented");

endmodule
